// ===== rtl/core/terminal_escape_key_decoder_assert.svh =====
// Assertion macros for the terminal escape key decoder.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef TERMINAL_ESCAPE_KEY_DECODER_ASSERT_SVH
`define TERMINAL_ESCAPE_KEY_DECODER_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define TEKD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define TEKD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tekd_pkg.sv =====
// Shared types and constants for the terminal escape key decoder.
// No dependencies; used by the channel interfaces and the top level.
package tekd_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [8:0] key_code_t;

    // Input event kinds
    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_EXPIRED = 1'b1;

    // Bytes of interest
    localparam byte_t BYTE_ESC    = 8'h1b;
    localparam byte_t BYTE_CSI    = 8'h5b;  // '['
    localparam byte_t BYTE_SS3    = 8'h4f;  // 'O'
    localparam byte_t BYTE_TILDE  = 8'h7e;  // '~'
    localparam byte_t BYTE_ZERO   = 8'h30;  // '0'
    localparam byte_t BYTE_NINE   = 8'h39;  // '9'
    localparam byte_t CTRL_MASK   = 8'h1f;
    localparam byte_t BYTE_CTRL_Q = 8'h71 & CTRL_MASK;
    localparam byte_t BYTE_CTRL_C = 8'h63 & CTRL_MASK;

    // Key codes above the plain byte range
    localparam key_code_t KEY_LEFT   = 9'd256;
    localparam key_code_t KEY_RIGHT  = 9'd257;
    localparam key_code_t KEY_UP     = 9'd258;
    localparam key_code_t KEY_DOWN   = 9'd259;
    localparam key_code_t KEY_DELETE = 9'd260;
    localparam key_code_t KEY_HOME   = 9'd261;
    localparam key_code_t KEY_END    = 9'd262;
    localparam key_code_t KEY_PGUP   = 9'd263;
    localparam key_code_t KEY_PGDN   = 9'd264;
    localparam key_code_t KEY_ESC    = 9'd265;

endpackage

// ===== rtl/core/tekd_in_if.sv =====
// Input channel of the terminal escape key decoder: one event per transfer.
// Depends on tekd_pkg for the byte type.
interface tekd_in_if;
    logic            valid;
    logic            ready;
    logic            cmd;
    tekd_pkg::byte_t in_byte;

    modport source (output valid, output cmd, output in_byte, input ready);
    modport sink   (input valid, input cmd, input in_byte, output ready);
endinterface

// ===== rtl/core/tekd_out_if.sv =====
// Output channel of the terminal escape key decoder: one key per transfer.
// Depends on tekd_pkg for the key code type.
interface tekd_out_if;
    logic                valid;
    logic                ready;
    tekd_pkg::key_code_t key_code;
    logic                quit;

    modport source (output valid, output key_code, output quit, input ready);
    modport sink   (input valid, input key_code, input quit, output ready);
endinterface

// ===== rtl/core/terminal_escape_key_decoder.sv =====
// Top level of the terminal escape key decoder: parser state and result register.
// Depends on tekd_pkg, tekd_in_if, tekd_out_if and terminal_escape_key_decoder_assert.svh.
//
// Usage:
//   in_ch carries one event per transfer: cmd 0 with a received byte in in_byte,
//   or cmd 1 for a wait that expired with no byte.
//   out_ch carries one key per transfer: key_code (plain byte 0-255 or a named
//   key 256-265) and quit, set for Ctrl-Q and Ctrl-C.
//   An event gives zero or one key. A key is presented in the cycle after the
//   transfer of the event that completes it, from a single result register.
//   Throughput is one event per cycle while the receiver does not stall: the
//   parser state updates in the same cycle as the input transfer, so events follow back to back.
//   in_ch.ready is high while the result register is empty or being emptied;
//   when the receiver stalls with a key pending, ready drops and the key holds.
//   Reset puts the parser in idle and empties the result register, so a pending
//   key is lost; no key is produced by reset itself.
//   Wait expiry after ESC or after its first following byte gives the ESC key;
//   expiry while idle or while the closing '~' is awaited gives nothing.
`include "terminal_escape_key_decoder_assert.svh"

module terminal_escape_key_decoder (
    input  logic       clk,
    input  logic       rst_n,
    tekd_in_if.sink    in_ch,
    tekd_out_if.source out_ch
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_FIRST,
        MODE_SECOND,
        MODE_FINAL
    } mode_t;

    mode_t                mode_reg;
    mode_t                mode_next;
    tekd_pkg::byte_t      first_reg;
    tekd_pkg::byte_t      first_next;
    tekd_pkg::byte_t      digit_reg;
    tekd_pkg::byte_t      digit_next;
    logic                 out_valid_reg;
    tekd_pkg::key_code_t  key_code_reg;
    logic                 quit_reg;

    logic                 in_fire;
    logic                 emit;
    tekd_pkg::key_code_t  emit_key;
    logic                 expired;
    logic                 is_digit;

    // Map the two bytes after ESC to a key
    function automatic tekd_pkg::key_code_t decode_pair(tekd_pkg::byte_t first,
                                                         tekd_pkg::byte_t second);
        tekd_pkg::key_code_t key;
        key = tekd_pkg::KEY_ESC;
        if (first == tekd_pkg::BYTE_CSI)
        begin
            case (second)
                8'h41:   key = tekd_pkg::KEY_UP;
                8'h42:   key = tekd_pkg::KEY_DOWN;
                8'h43:   key = tekd_pkg::KEY_RIGHT;
                8'h44:   key = tekd_pkg::KEY_LEFT;
                8'h48:   key = tekd_pkg::KEY_HOME;
                8'h46:   key = tekd_pkg::KEY_END;
                default: key = tekd_pkg::KEY_ESC;
            endcase
        end
        else if (first == tekd_pkg::BYTE_SS3)
        begin
            case (second)
                8'h48:   key = tekd_pkg::KEY_HOME;
                8'h46:   key = tekd_pkg::KEY_END;
                default: key = tekd_pkg::KEY_ESC;
            endcase
        end
        return key;
    endfunction

    // Map the digit of ESC [ digit ~ to a key
    function automatic tekd_pkg::key_code_t decode_digit(tekd_pkg::byte_t digit);
        tekd_pkg::key_code_t key;
        case (digit)
            8'h31:   key = tekd_pkg::KEY_HOME;
            8'h33:   key = tekd_pkg::KEY_DELETE;
            8'h34:   key = tekd_pkg::KEY_END;
            8'h35:   key = tekd_pkg::KEY_PGUP;
            8'h36:   key = tekd_pkg::KEY_PGDN;
            8'h37:   key = tekd_pkg::KEY_HOME;
            8'h38:   key = tekd_pkg::KEY_END;
            default: key = tekd_pkg::KEY_ESC;
        endcase
        return key;
    endfunction

    // Accept a new event while the result register is empty or draining
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign expired     = (in_ch.cmd == tekd_pkg::CMD_EXPIRED);
    assign is_digit    = (in_ch.in_byte >= tekd_pkg::BYTE_ZERO)
                      && (in_ch.in_byte <= tekd_pkg::BYTE_NINE);

    // Decode the current event against the parser state
    always_comb
    begin
        mode_next  = mode_reg;
        first_next = first_reg;
        digit_next = digit_reg;
        emit       = 1'b0;
        emit_key   = tekd_pkg::KEY_ESC;
        case (mode_reg)
            MODE_FIRST:
            begin
                if (expired)
                begin
                    mode_next = MODE_IDLE;
                    emit      = 1'b1;
                end
                else
                begin
                    first_next = in_ch.in_byte;
                    mode_next  = MODE_SECOND;
                end
            end
            MODE_SECOND:
            begin
                if (expired)
                begin
                    mode_next = MODE_IDLE;
                    emit      = 1'b1;
                end
                else if (first_reg == tekd_pkg::BYTE_CSI && is_digit)
                begin
                    digit_next = in_ch.in_byte;
                    mode_next  = MODE_FINAL;
                end
                else
                begin
                    mode_next = MODE_IDLE;
                    emit      = 1'b1;
                    emit_key  = decode_pair(first_reg, in_ch.in_byte);
                end
            end
            MODE_FINAL:
            begin
                if (!expired)
                begin
                    mode_next = MODE_IDLE;
                    emit      = 1'b1;
                    if (in_ch.in_byte == tekd_pkg::BYTE_TILDE)
                    begin
                        emit_key = decode_digit(digit_reg);
                    end
                end
            end
            default:
            begin
                if (!expired)
                begin
                    if (in_ch.in_byte == tekd_pkg::BYTE_ESC)
                    begin
                        mode_next = MODE_FIRST;
                    end
                    else
                    begin
                        emit     = 1'b1;
                        emit_key = {1'b0, in_ch.in_byte};
                    end
                end
            end
        endcase
    end

    // Hold parser state and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            first_reg     <= '0;
            digit_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                mode_reg      <= mode_next;
                first_reg     <= first_next;
                digit_reg     <= digit_next;
                out_valid_reg <= emit;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load the key payload on a transfer that completes a key
    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            key_code_reg <= emit_key;
            quit_reg     <= (emit_key == {1'b0, tekd_pkg::BYTE_CTRL_Q})
                         || (emit_key == {1'b0, tekd_pkg::BYTE_CTRL_C});
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.key_code = key_code_reg;
    assign out_ch.quit     = quit_reg;

    // Checks on the parser and result register
    `TEKD_ASSERT_SAME(a_quit_matches_key, out_valid_reg,
        quit_reg == ((key_code_reg == 9'h011) || (key_code_reg == 9'h003)),
        "quit flag does not match key code")
    `TEKD_ASSERT_SAME(a_key_in_range, out_valid_reg, key_code_reg <= tekd_pkg::KEY_ESC,
        "key code out of range")
    `TEKD_ASSERT_SAME(a_ready_only_stalls, !in_ch.ready, out_valid_reg && !out_ch.ready,
        "input stalled without a pending key")
    `TEKD_ASSERT_NEXT(a_final_ignores_expiry,
        in_fire && mode_reg == MODE_FINAL && expired,
        mode_reg == MODE_FINAL && digit_reg == $past(digit_reg),
        "expiry disturbed the wait for the final byte")
    `TEKD_ASSERT_NEXT(a_esc_opens_sequence,
        in_fire && mode_reg == MODE_IDLE && !expired && in_ch.in_byte == tekd_pkg::BYTE_ESC,
        mode_reg == MODE_FIRST,
        "ESC did not open a sequence")

endmodule

// ===== tb/terminal_escape_key_decoder_tb.sv =====
// Self-checking testbench for the terminal escape key decoder.
// Depends on tekd_pkg, tekd_in_if, tekd_out_if and the terminal_escape_key_decoder top level.
// A scoreboard class predicts each key from accepted events; tasks drive the input channel.
module terminal_escape_key_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int EVENT_TARGET = 1300;
    localparam int STALL_PCT    = 31;
    localparam int WATCHDOG_MAX = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int CALM_FIRST   = 500;
    localparam int CALM_LAST    = 700;

    // Characters that steer the escape parser
    localparam tekd_pkg::byte_t CH_A     = 8'h41;
    localparam tekd_pkg::byte_t CH_B     = 8'h42;
    localparam tekd_pkg::byte_t CH_C     = 8'h43;
    localparam tekd_pkg::byte_t CH_D     = 8'h44;
    localparam tekd_pkg::byte_t CH_F     = 8'h46;
    localparam tekd_pkg::byte_t CH_H     = 8'h48;
    localparam tekd_pkg::byte_t CH_Z     = 8'h5a;
    localparam tekd_pkg::byte_t DIGIT_1  = 8'h31;
    localparam tekd_pkg::byte_t DIGIT_3  = 8'h33;
    localparam tekd_pkg::byte_t DIGIT_4  = 8'h34;
    localparam tekd_pkg::byte_t DIGIT_5  = 8'h35;
    localparam tekd_pkg::byte_t DIGIT_6  = 8'h36;
    localparam tekd_pkg::byte_t DIGIT_7  = 8'h37;
    localparam tekd_pkg::byte_t DIGIT_8  = 8'h38;

    typedef enum logic [2:0] {
        PARSE_IDLE,
        PARSE_FIRST,
        PARSE_SECOND,
        PARSE_FINAL
    } parse_state_t;

    typedef struct packed {
        tekd_pkg::key_code_t key_code;
        logic                quit;
    } key_result_t;

    typedef struct packed {
        logic            cmd;
        tekd_pkg::byte_t in_byte;
    } term_event_t;

    // Key predictor and store of expected keys
    class key_scoreboard;
        parse_state_t    state = PARSE_IDLE;
        tekd_pkg::byte_t lead_byte = '0;
        tekd_pkg::byte_t digit_byte = '0;
        key_result_t     expected_keys[$];
        int              failures = 0;

        function automatic tekd_pkg::key_code_t pair_key(tekd_pkg::byte_t lead,
                                                         tekd_pkg::byte_t b);
            if (lead == tekd_pkg::BYTE_CSI)
            begin
                case (b)
                    CH_A: return tekd_pkg::KEY_UP;
                    CH_B: return tekd_pkg::KEY_DOWN;
                    CH_C: return tekd_pkg::KEY_RIGHT;
                    CH_D: return tekd_pkg::KEY_LEFT;
                    CH_H: return tekd_pkg::KEY_HOME;
                    CH_F: return tekd_pkg::KEY_END;
                    default: return tekd_pkg::KEY_ESC;
                endcase
            end
            if (lead == tekd_pkg::BYTE_SS3 && b == CH_H) return tekd_pkg::KEY_HOME;
            if (lead == tekd_pkg::BYTE_SS3 && b == CH_F) return tekd_pkg::KEY_END;
            return tekd_pkg::KEY_ESC;
        endfunction

        function automatic tekd_pkg::key_code_t digit_key(tekd_pkg::byte_t d);
            case (d)
                DIGIT_1: return tekd_pkg::KEY_HOME;
                DIGIT_3: return tekd_pkg::KEY_DELETE;
                DIGIT_4: return tekd_pkg::KEY_END;
                DIGIT_5: return tekd_pkg::KEY_PGUP;
                DIGIT_6: return tekd_pkg::KEY_PGDN;
                DIGIT_7: return tekd_pkg::KEY_HOME;
                DIGIT_8: return tekd_pkg::KEY_END;
                default: return tekd_pkg::KEY_ESC;
            endcase
        endfunction

        function automatic void push_key(tekd_pkg::key_code_t k);
            key_result_t r;
            r.key_code = k;
            r.quit = (k == {1'b0, tekd_pkg::BYTE_CTRL_Q}) || (k == {1'b0, tekd_pkg::BYTE_CTRL_C});
            expected_keys.push_back(r);
        endfunction

        // Advance the parser by one accepted event
        function automatic void note_event(logic cmd, tekd_pkg::byte_t b);
            logic expired;
            expired = (cmd == tekd_pkg::CMD_EXPIRED);
            case (state)
                PARSE_FIRST:
                begin
                    if (expired)
                    begin
                        state = PARSE_IDLE;
                        push_key(tekd_pkg::KEY_ESC);
                    end
                    else
                    begin
                        lead_byte = b;
                        state = PARSE_SECOND;
                    end
                end
                PARSE_SECOND:
                begin
                    if (expired)
                    begin
                        state = PARSE_IDLE;
                        push_key(tekd_pkg::KEY_ESC);
                    end
                    else if (lead_byte == tekd_pkg::BYTE_CSI && b >= tekd_pkg::BYTE_ZERO
                             && b <= tekd_pkg::BYTE_NINE)
                    begin
                        digit_byte = b;
                        state = PARSE_FINAL;
                    end
                    else
                    begin
                        state = PARSE_IDLE;
                        push_key(pair_key(lead_byte, b));
                    end
                end
                PARSE_FINAL:
                begin
                    if (!expired)
                    begin
                        state = PARSE_IDLE;
                        push_key((b == tekd_pkg::BYTE_TILDE) ? digit_key(digit_byte)
                                                             : tekd_pkg::KEY_ESC);
                    end
                end
                default:
                begin
                    state = PARSE_IDLE;
                    if (!expired)
                    begin
                        if (b == tekd_pkg::BYTE_ESC) state = PARSE_FIRST;
                        else push_key({1'b0, b});
                    end
                end
            endcase
        endfunction

        // Compare one delivered key with the oldest expectation
        function automatic void check_key(tekd_pkg::key_code_t k, logic q);
            key_result_t exp_key;
            if (expected_keys.size() == 0)
            begin
                $error("unexpected key: key_code %0d quit %0d", k, q);
                failures++;
                return;
            end
            exp_key = expected_keys.pop_front();
            if (k !== exp_key.key_code)
            begin
                $error("key_code expected %0d actual %0d", exp_key.key_code, k);
                failures++;
            end
            if (q !== exp_key.quit)
            begin
                $error("quit expected %0d actual %0d", exp_key.quit, q);
                failures++;
            end
        endfunction

        function automatic int pending();
            return expected_keys.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic calm = 1'b0;

    tekd_in_if  in_ch ();
    tekd_out_if out_ch ();

    key_scoreboard sb = new();
    term_event_t   events[$];

    terminal_escape_key_decoder u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #2 clk = ~clk;

    // Stall the key receiver at random, except in the calm window
    always @(posedge clk)
    begin
        out_ch.ready <= calm || ($urandom_range(99) >= STALL_PCT);
    end

    // Record transfers on both channels; keys first, they stem from earlier events
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready) sb.check_key(out_ch.key_code, out_ch.quit);
            if (in_ch.valid && in_ch.ready) sb.note_event(in_ch.cmd, in_ch.in_byte);
        end
    end

    // End the run when neither channel has moved for too long
    always @(posedge clk)
    begin : watchdog
        int quiet_cycles;
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_MAX)
            begin
                $display("terminal_escape_key_decoder_tb: FAIL");
                $finish;
            end
        end
    end

    task automatic add_byte(tekd_pkg::byte_t b);
        events.push_back(term_event_t'{cmd: tekd_pkg::CMD_BYTE, in_byte: b});
    endtask

    task automatic add_expiry();
        events.push_back(term_event_t'{cmd: tekd_pkg::CMD_EXPIRED,
                                       in_byte: tekd_pkg::byte_t'($urandom_range(255))});
    endtask

    // Hand-picked events: extremes, a sample of keys and each corner of the parser
    task automatic build_directed();
        add_byte(8'h00);
        add_byte(8'hff);
        add_byte(tekd_pkg::BYTE_CTRL_C);
        add_byte(tekd_pkg::BYTE_CTRL_Q);
        add_expiry();                       // expiry while idle
        add_byte(tekd_pkg::BYTE_ESC); add_byte(tekd_pkg::BYTE_CSI); add_byte(CH_A);
        add_byte(tekd_pkg::BYTE_ESC); add_byte(tekd_pkg::BYTE_SS3); add_byte(CH_F);
        add_byte(tekd_pkg::BYTE_ESC); add_byte(tekd_pkg::BYTE_CSI); add_byte(DIGIT_3);
        add_byte(tekd_pkg::BYTE_TILDE);
        add_byte(tekd_pkg::BYTE_ESC); add_expiry();   // expiry right after ESC
        add_byte(tekd_pkg::BYTE_ESC); add_byte(tekd_pkg::BYTE_CSI); add_expiry();
        // expiry ignored while the final byte is due, then a wrong final byte
        add_byte(tekd_pkg::BYTE_ESC); add_byte(tekd_pkg::BYTE_CSI); add_byte(DIGIT_5);
        add_expiry(); add_byte(CH_Z);
        // ESC inside a sequence is just another sequence byte
        add_byte(tekd_pkg::BYTE_ESC); add_byte(tekd_pkg::BYTE_ESC); add_byte(tekd_pkg::BYTE_ESC);
    endtask

    function automatic tekd_pkg::byte_t csi_letter();
        tekd_pkg::byte_t letters[6] = '{CH_A, CH_B, CH_C, CH_D, CH_H, CH_F};
        if ($urandom_range(3) != 0) return letters[$urandom_range(5)];
        return tekd_pkg::byte_t'($urandom_range(255));
    endfunction

    // Mostly well-formed sequences with random content, the rest noise
    task automatic build_random();
        int n;
        while (events.size() < EVENT_TARGET)
        begin
            case ($urandom_range(9))
                0, 1:
                begin
                    add_byte(tekd_pkg::BYTE_ESC); add_byte(tekd_pkg::BYTE_CSI);
                    add_byte(csi_letter());
                end
                2:
                begin
                    add_byte(tekd_pkg::BYTE_ESC); add_byte(tekd_pkg::BYTE_SS3);
                    case ($urandom_range(2))
                        0: add_byte(CH_H);
                        1: add_byte(CH_F);
                        default: add_byte(tekd_pkg::byte_t'($urandom_range(255)));
                    endcase
                end
                3, 4:
                begin
                    add_byte(tekd_pkg::BYTE_ESC); add_byte(tekd_pkg::BYTE_CSI);
                    add_byte(tekd_pkg::byte_t'($urandom_range(tekd_pkg::BYTE_NINE,
                                                              tekd_pkg::BYTE_ZERO)));
                    n = ($urandom_range(3) == 0) ? $urandom_range(3) : 0;
                    repeat (n) add_expiry();
                    if ($urandom_range(4) != 0) add_byte(tekd_pkg::BYTE_TILDE);
                    else add_byte(tekd_pkg::byte_t'($urandom_range(255)));
                end
                5:
                begin
                    // broken sequence cut short by an expiry
                    add_byte(tekd_pkg::BYTE_ESC);
                    if ($urandom_range(1)) add_byte(tekd_pkg::byte_t'($urandom_range(255)));
                    add_expiry();
                end
                6:
                begin
                    add_byte(tekd_pkg::BYTE_ESC);
                    add_byte(tekd_pkg::byte_t'($urandom_range(255)));
                    add_byte(tekd_pkg::byte_t'($urandom_range(255)));
                end
                7:
                begin
                    add_expiry();
                end
                default:
                begin
                    add_byte(tekd_pkg::byte_t'($urandom_range(255)));
                end
            endcase
        end
    endtask

    // Present one event and hold it until it transfers
    task automatic drive_event(term_event_t ev);
        while (!calm && $urandom_range(99) < STALL_PCT)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.cmd     <= ev.cmd;
        in_ch.in_byte <= ev.in_byte;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.cmd     <= tekd_pkg::CMD_BYTE;
        in_ch.in_byte <= '0;

        build_directed();
        build_random();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (events[i])
        begin
            calm = (i >= CALM_FIRST && i < CALM_LAST);
            drive_event(events[i]);
        end
        in_ch.valid <= 1'b0;
        calm = 1'b0;

        // Drain outstanding keys, then give the block time to show anything stray
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.failures == 0 && sb.pending() == 0)
        begin
            $display("terminal_escape_key_decoder_tb: PASS");
        end
        else
        begin
            $display("terminal_escape_key_decoder_tb: FAIL");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/tekd_pkg.sv
rtl/core/tekd_in_if.sv
rtl/core/tekd_out_if.sv
rtl/core/terminal_escape_key_decoder.sv
tb/terminal_escape_key_decoder_tb.sv
